// ===== rtl/core/erm_pkg.sv =====
// Shared types, field layout and constants for the encoder referenced stepper mover.
package erm_pkg;

	localparam int COUNT_WIDTH_DEF      = 24;
	localparam int STEP_COUNT_WIDTH_DEF = 24;

	localparam int TARGET_W   = 17;
	localparam int TIMER_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int POS_W      = 24;
	localparam int STEPS_W    = 24;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;

	localparam logic [TIMER_W-1:0] PERIOD_RESET = 16'd1000;
	localparam logic [TIMER_W-1:0] HIGH_RESET   = 16'd50;

	// steps = trunc(delta * STEP_MUL / STEP_DIV)
	localparam int STEP_MUL = 50;
	localparam int STEP_DIV = 9;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH  = 1'd1;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_EDGE = 2'd1,
		OP_MOVE = 2'd2,
		OP_HOME = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_HOME = 2'd2
	} mode_t;

	typedef struct packed {
		opcode_t                     opcode;
		logic                        home_switch;
		logic                        channel_a_level;
		logic signed [TARGET_W-1:0]  target_tenths;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         pad;
		logic [STEPS_W-1:0] steps_remaining;
		logic [POS_W-1:0]   position_count;
		logic               rejected;
		mode_t              mode;
		logic               direction;
		logic               step_pulse;
	} out_item_t;

	// floor(r * 50 / 9) for a remainder of the division by nine
	function automatic logic [5:0] step_frac(input logic [3:0] r);
		logic [5:0] v;
		case (r)
			4'd0: v = 6'd0;
			4'd1: v = 6'd5;
			4'd2: v = 6'd11;
			4'd3: v = 6'd16;
			4'd4: v = 6'd22;
			4'd5: v = 6'd27;
			4'd6: v = 6'd33;
			4'd7: v = 6'd38;
			4'd8: v = 6'd44;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/erm_step_calc.sv =====
// Move command step count: target minus encoder count, scaled by 50/9, saturated.
module erm_step_calc #(
	parameter int COUNT_WIDTH      = erm_pkg::COUNT_WIDTH_DEF,
	parameter int STEP_COUNT_WIDTH = erm_pkg::STEP_COUNT_WIDTH_DEF
) (
	input  logic signed [erm_pkg::TARGET_W-1:0] target,
	input  logic [COUNT_WIDTH-1:0]              count,
	output logic [STEP_COUNT_WIDTH-1:0]         steps,
	output logic                                dir_neg
);
	import erm_pkg::*;

	localparam int DW = COUNT_WIDTH + 2;
	localparam longint unsigned CAP = (64'd1 << STEP_COUNT_WIDTH) - 64'd1;
	// smallest magnitude that already reaches the cap
	localparam longint unsigned CLAMP =
		((64'd1 << STEP_COUNT_WIDTH) * STEP_DIV) / STEP_MUL + 64'd1;
	localparam int DIV_W = $clog2(CLAMP + 64'd1);
	localparam int CMP_W = (DW > DIV_W) ? DW : DIV_W;
	localparam int K     = DIV_W + 4;
	localparam longint unsigned RECIP = (64'd1 << K) / STEP_DIV + 64'd1;
	localparam int PW    = DIV_W + K;
	localparam int FW    = DIV_W + 6;

	logic signed [DW-1:0] delta;
	logic [DW-1:0]        mag;
	logic [DIV_W-1:0]     x;
	logic [PW-1:0]        prod;
	logic [DIV_W-1:0]     quo;
	logic [DIV_W-1:0]     rem_w;
	logic [FW-1:0]        full;

	always_comb begin
		delta = DW'(target) - DW'($signed(count));
		mag   = delta[DW-1] ? DW'(-delta) : DW'(delta);
		x     = (CMP_W'(mag) > CMP_W'(CLAMP)) ? DIV_W'(CLAMP) : DIV_W'(mag);
		prod  = PW'(x) * PW'(RECIP);
		quo   = prod[PW-1:K];
		rem_w = x - (quo << 3) - quo;
		full  = FW'(quo) * FW'(STEP_MUL) + FW'(step_frac(rem_w[3:0]));
		steps = (full > FW'(CAP)) ? STEP_COUNT_WIDTH'(CAP) : full[STEP_COUNT_WIDTH-1:0];
		dir_neg = delta[DW-1];
	end

endmodule

// ===== rtl/core/encoder_referenced_stepper_mover_top.sv =====
// Top level of the encoder referenced stepper mover: handshakes, state and result register.
//
// channel  | dir | beat contents
// s_*      | in  | tick, encoder edge, move or home command
// m_*      | out | one status beat per input beat
// cfg_*    | in  | step period and pulse high time writes
//
// One input beat enters the input register, and its result is registered in the output
// register; one beat per cycle sustained while the output is not stalled.
// The state update and the step count sit between those two registers.
// A stalled output holds its beat; the input register still takes one more beat.
// Reset clears all state and the configuration to 1000 and 50 ticks.
module encoder_referenced_stepper_mover_top #(
	parameter int COUNT_WIDTH      = erm_pkg::COUNT_WIDTH_DEF,
	parameter int STEP_COUNT_WIDTH = erm_pkg::STEP_COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// target_tenths[16:0], channel_a_level[17], home_switch[18], zero[23:19]
	input  logic [erm_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode[1:0]
	input  logic [erm_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// step_pulse[0], direction[1], mode[3:2], rejected[4],
	// position_count[28:5], steps_remaining[52:29], zero[55:53]
	output logic [erm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_wr_en,
	input  logic [erm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [erm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import erm_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;
	logic      out_free;
	logic      fire_s1;

	logic [TIMER_W-1:0]          cfg_period_q;
	logic [TIMER_W-1:0]          cfg_high_q;
	logic [COUNT_WIDTH-1:0]      count_q, n_count;
	logic [STEP_COUNT_WIDTH-1:0] steps_q, n_steps;
	logic [TIMER_W-1:0]          period_q, n_period;
	logic [TIMER_W-1:0]          high_q, n_high;
	mode_t                       mode_q, n_mode;
	logic                        dir_q, n_dir;
	logic                        pulse_q, n_pulse;
	logic                        rej;
	logic [TIMER_W-1:0]          cd_period, cd_high;
	logic                        cd_pulse;
	logic [STEP_COUNT_WIDTH-1:0] move_steps;
	logic                        move_neg;
	out_item_t                   n_out;

	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	erm_step_calc #(
		.COUNT_WIDTH      (COUNT_WIDTH),
		.STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
	) u_step_calc (
		.target  (item_s1.target_tenths),
		.count   (count_q),
		.steps   (move_steps),
		.dir_neg (move_neg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.target_tenths   <= s_tdata[TARGET_W-1:0];
			item_s1.channel_a_level <= s_tdata[TARGET_W];
			item_s1.home_switch     <= s_tdata[TARGET_W+1];
			item_s1.opcode          <= opcode_t'(s_tuser);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_period_q <= PERIOD_RESET;
			cfg_high_q   <= HIGH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STEP_PERIOD: cfg_period_q <= cfg_wdata;
				REG_PULSE_HIGH:  cfg_high_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cd_high   = (high_q != '0) ? high_q - TIMER_W'(1) : '0;
		cd_pulse  = (high_q == TIMER_W'(1)) ? 1'b0 : pulse_q;
		cd_period = (period_q != '0) ? period_q - TIMER_W'(1) : '0;

		n_count  = count_q;
		n_steps  = steps_q;
		n_period = period_q;
		n_high   = high_q;
		n_mode   = mode_q;
		n_dir    = dir_q;
		n_pulse  = pulse_q;
		rej      = 1'b0;

		if (fire_s1) begin
			case (item_s1.opcode)
				OP_TICK: begin
					case (mode_q)
						MODE_MOVE: begin
							n_high   = cd_high;
							n_pulse  = cd_pulse;
							n_period = cd_period;
							if (cd_period == '0) begin
								if (steps_q != '0) begin
									n_steps  = steps_q - STEP_COUNT_WIDTH'(1);
									n_high   = cfg_high_q;
									n_pulse  = (cfg_high_q != '0);
									n_period = cfg_period_q;
								end else begin
									n_mode   = MODE_IDLE;
									n_pulse  = 1'b0;
									n_period = '0;
									n_high   = '0;
								end
							end
						end
						MODE_HOME: begin
							if (!item_s1.home_switch) begin
								n_mode   = MODE_IDLE;
								n_pulse  = 1'b0;
								n_period = '0;
								n_high   = '0;
								n_count  = '0;
							end else begin
								n_high   = cd_high;
								n_pulse  = cd_pulse;
								n_period = cd_period;
								if (cd_period == '0) begin
									n_high   = cfg_period_q >> 1;
									n_pulse  = (cfg_period_q[TIMER_W-1:1] != '0);
									n_period = cfg_period_q;
								end
							end
						end
						default: ;
					endcase
				end
				OP_EDGE: begin
					n_count = item_s1.channel_a_level ? count_q + COUNT_WIDTH'(1)
					                                  : count_q - COUNT_WIDTH'(1);
				end
				OP_MOVE: begin
					if (mode_q != MODE_IDLE) begin
						rej = 1'b1;
					end else begin
						n_dir    = !move_neg;
						n_steps  = move_steps;
						n_period = '0;
						n_high   = '0;
						n_pulse  = 1'b0;
						n_mode   = (move_steps != '0) ? MODE_MOVE : MODE_IDLE;
					end
				end
				OP_HOME: begin
					if (mode_q != MODE_IDLE) begin
						rej = 1'b1;
					end else begin
						n_mode   = MODE_HOME;
						n_dir    = 1'b0;
						n_pulse  = 1'b0;
						n_period = '0;
						n_high   = '0;
					end
				end
				default: ;
			endcase
		end

		n_out.pad             = '0;
		n_out.steps_remaining = STEPS_W'(n_steps);
		n_out.position_count  = POS_W'($signed(n_count));
		n_out.rejected        = rej;
		n_out.mode            = n_mode;
		n_out.direction       = n_dir;
		n_out.step_pulse      = n_pulse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			steps_q  <= '0;
			period_q <= '0;
			high_q   <= '0;
			mode_q   <= MODE_IDLE;
			dir_q    <= 1'b0;
			pulse_q  <= 1'b0;
		end else begin
			count_q  <= n_count;
			steps_q  <= n_steps;
			period_q <= n_period;
			high_q   <= n_high;
			mode_q   <= n_mode;
			dir_q    <= n_dir;
			pulse_q  <= n_pulse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= n_out;
		end
	end

`ifndef ASSERT_OFF
	a_idle_pulse_low: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> !pulse_q)
		else $error("step pulse high while idle");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> out_valid_q && !m_tready)
		else $error("input blocked without an output stall");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.rejected |-> out_q.mode != MODE_IDLE)
		else $error("command rejected while idle");

	a_home_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.opcode == OP_TICK && mode_q == MODE_HOME && !item_s1.home_switch
		|=> count_q == '0 && mode_q == MODE_IDLE)
		else $error("home end did not zero the count");
`endif

endmodule
